// ----- rtl/coordinate_descent_gain_tuner_macros.svh -----
// ----------------------------------------------------------------------------
// Gain tuner assertion macros
// Shared concurrent assertion forms for the tuner checker.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_DESCENT_GAIN_TUNER_MACROS_SVH
`define COORDINATE_DESCENT_GAIN_TUNER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CDGT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define CDGT_ASSERT_NEVER(lbl, cond, msg) \
  `CDGT_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/cdgt_pkg.sv -----
// ----------------------------------------------------------------------------
// Gain tuner package
// Types, constants and arithmetic helpers shared by the tuner modules.
// ----------------------------------------------------------------------------
package cdgt_pkg;

  localparam int unsigned NumGains = 3;

  // Trial phase, one-hot inside the block.
  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_POS   = 3'b010,
    PH_NEG   = 3'b100
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_STEP_P    = 3'd3,
    CFG_STEP_I    = 3'd4,
    CFG_STEP_D    = 3'd5,
    CFG_STEP_LOW  = 3'd6,
    CFG_STEP_HIGH = 3'd7
  } cfg_idx_e;

  localparam logic [1:0] IDX_FIRST = 2'd0;
  localparam logic [1:0] IDX_LAST  = 2'd2;

  // Q16.16 step multipliers: 1.1, 1.05, 0.9.
  localparam logic [16:0] K_WIDEN_POS = 17'd72090;
  localparam logic [16:0] K_WIDEN_NEG = 17'd68813;
  localparam logic [16:0] K_SHRINK    = 17'd58982;

  // 1.0 in Q16.16; step sum limit: 100 * sum < 2^24 holds exactly for sum <= 167772.
  localparam logic [31:0] COST_ONE     = 32'h0001_0000;
  localparam logic [33:0] STEP_SUM_MAX = 34'd167772;

  localparam logic [31:0] RST_GAIN_P    = 32'd3355443;
  localparam logic [31:0] RST_GAIN_I    = 32'd67109;
  localparam logic [31:0] RST_GAIN_D    = 32'd50331648;
  localparam logic [31:0] RST_STEP      = 32'd1677722;
  localparam logic [31:0] RST_STEP_LOW  = 32'h0000_0000;
  localparam logic [31:0] RST_STEP_HIGH = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_BEST      = 32'hFFFF_FFFF;

  localparam logic [1:0] PHASE_CODE_FIRST = 2'd0;
  localparam logic [1:0] PHASE_CODE_POS   = 2'd1;
  localparam logic [1:0] PHASE_CODE_NEG   = 2'd2;
  localparam logic [1:0] PHASE_CODE_BAD   = 2'd3;

  typedef logic [NumGains-1:0][31:0] word3_t;

  typedef struct packed {
    word3_t      gain;
    word3_t      step;
    logic [31:0] best;
    logic [1:0]  idx;
    phase_e      phase;
  } tune_state_t;

  function automatic logic [1:0] phase_code(phase_e p);
    logic [1:0] c;
    unique case (p)
      PH_FIRST: c = PHASE_CODE_FIRST;
      PH_POS:   c = PHASE_CODE_POS;
      PH_NEG:   c = PHASE_CODE_NEG;
      default:  c = PHASE_CODE_BAD;
    endcase
    return c;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic [31:0] sat_gain(logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // (step * k) >> 16, truncating, saturating at all ones.
  function automatic logic [31:0] scale_step(logic [31:0] s, logic [16:0] k);
    logic [48:0] p;
    logic [31:0] r;
    p = {17'b0, s} * {32'b0, k};
    if (p[48]) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = p[47:16];
    end
    return r;
  endfunction

endpackage

// ----- rtl/coordinate_descent_gain_tuner.sv -----
// ----------------------------------------------------------------------------
// Coordinate descent gain tuner
// Twiddle tuner for three controller gains, one trial cost per item.
// ----------------------------------------------------------------------------
// Pipeline: the cost register feeds the state update with the step multiply,
//   whose result loads the snapshot register; the completion check then loads
//   the output register.
// Throughput: one item per cycle unless the output stalls; the update is combinational.
// Reset: gains and steps load the initial register defaults, best cost goes
//   to all ones, index to the proportional gain and phase to first run.
module coordinate_descent_gain_tuner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        trial_cost_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] gain_p_o,
  output logic signed [31:0] gain_i_o,
  output logic signed [31:0] gain_d_o,
  output logic [31:0]        step_p_o,
  output logic [31:0]        step_i_o,
  output logic [31:0]        step_d_o,
  output logic [1:0]         tuned_index_o,
  output logic [1:0]         trial_phase_o,
  output logic [31:0]        best_cost_o,
  output logic               done_res_o
);

  cdgt_pkg::word3_t      init_gain_q, init_gain_d;
  cdgt_pkg::word3_t      init_step_q, init_step_d;
  logic [31:0]           step_low_q, step_low_d;
  logic [31:0]           step_high_q, step_high_d;
  cdgt_pkg::tune_state_t state_q, state_d;
  cdgt_pkg::tune_state_t state_nxt;

  logic                  cost_vld_q;
  logic [31:0]           cost_q;
  logic                  snap_vld_q;
  cdgt_pkg::tune_state_t snap_q;
  logic                  out_vld_q;
  cdgt_pkg::tune_state_t out_q;
  logic                  out_done_q;

  logic                  out_adv;
  logic                  snap_adv;
  logic                  in_ready;
  logic                  upd_go;
  logic [33:0]           step_sum;
  logic                  done_d;

  // Pipeline control: a stage loads when it is empty or its item moves on.
  assign out_adv    = !out_vld_q || !out_stall_i;
  assign snap_adv   = !snap_vld_q || out_adv;
  assign in_ready   = !cost_vld_q || snap_adv;
  assign upd_go     = cost_vld_q && snap_adv;
  assign in_stall_o = !in_ready;

  cdgt_update u_update (
    .cur_i  (state_q),
    .cost_i (cost_q),
    .nxt_o  (state_nxt)
  );

  always_comb begin
    init_gain_d = init_gain_q;
    init_step_d = init_step_q;
    step_low_d  = step_low_q;
    step_high_d = step_high_q;
    state_d     = state_q;
    priority if (cfg_we_i) begin
      // Before the first cost an initial value also loads the live gain or step.
      unique case (cdgt_pkg::cfg_idx_e'(cfg_idx_i))
        cdgt_pkg::CFG_GAIN_P: begin
          init_gain_d[0] = cfg_data_i;
          if (state_q.phase == cdgt_pkg::PH_FIRST) state_d.gain[0] = cfg_data_i;
        end
        cdgt_pkg::CFG_GAIN_I: begin
          init_gain_d[1] = cfg_data_i;
          if (state_q.phase == cdgt_pkg::PH_FIRST) state_d.gain[1] = cfg_data_i;
        end
        cdgt_pkg::CFG_GAIN_D: begin
          init_gain_d[2] = cfg_data_i;
          if (state_q.phase == cdgt_pkg::PH_FIRST) state_d.gain[2] = cfg_data_i;
        end
        cdgt_pkg::CFG_STEP_P: begin
          init_step_d[0] = cfg_data_i;
          if (state_q.phase == cdgt_pkg::PH_FIRST) state_d.step[0] = cfg_data_i;
        end
        cdgt_pkg::CFG_STEP_I: begin
          init_step_d[1] = cfg_data_i;
          if (state_q.phase == cdgt_pkg::PH_FIRST) state_d.step[1] = cfg_data_i;
        end
        cdgt_pkg::CFG_STEP_D: begin
          init_step_d[2] = cfg_data_i;
          if (state_q.phase == cdgt_pkg::PH_FIRST) state_d.step[2] = cfg_data_i;
        end
        cdgt_pkg::CFG_STEP_LOW:  step_low_d  = cfg_data_i;
        cdgt_pkg::CFG_STEP_HIGH: step_high_d = cfg_data_i;
        default: ;
      endcase
    end else if (upd_go) begin
      state_d = state_nxt;
    end else begin
      // Hold the tuner state while no item is updating.
      state_d = state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_gain_q   <= {cdgt_pkg::RST_GAIN_D, cdgt_pkg::RST_GAIN_I, cdgt_pkg::RST_GAIN_P};
      init_step_q   <= {cdgt_pkg::RST_STEP, cdgt_pkg::RST_STEP, cdgt_pkg::RST_STEP};
      step_low_q    <= cdgt_pkg::RST_STEP_LOW;
      step_high_q   <= cdgt_pkg::RST_STEP_HIGH;
      state_q.gain  <= {cdgt_pkg::RST_GAIN_D, cdgt_pkg::RST_GAIN_I, cdgt_pkg::RST_GAIN_P};
      state_q.step  <= {cdgt_pkg::RST_STEP, cdgt_pkg::RST_STEP, cdgt_pkg::RST_STEP};
      state_q.best  <= cdgt_pkg::RST_BEST;
      state_q.idx   <= cdgt_pkg::IDX_FIRST;
      state_q.phase <= cdgt_pkg::PH_FIRST;
      cost_vld_q    <= 1'b0;
      snap_vld_q    <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      init_gain_q <= init_gain_d;
      init_step_q <= init_step_d;
      step_low_q  <= step_low_d;
      step_high_q <= step_high_d;
      state_q     <= state_d;
      if (in_ready) cost_vld_q <= in_valid_i;
      if (snap_adv) snap_vld_q <= cost_vld_q;
      if (out_adv)  out_vld_q  <= snap_vld_q;
    end
  end

  // Completion: small step sum, low best cost, every step inside the bounds.
  always_comb begin
    step_sum = {2'b00, snap_q.step[0]} + {2'b00, snap_q.step[1]} + {2'b00, snap_q.step[2]};
    done_d   = (step_sum <= cdgt_pkg::STEP_SUM_MAX) && (snap_q.best < cdgt_pkg::COST_ONE);
    for (int k = 0; k < cdgt_pkg::NumGains; k++) begin
      if (!(snap_q.step[k] > step_low_q && snap_q.step[k] < step_high_q)) done_d = 1'b0;
    end
  end

  // Payload registers: load with their stage, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) cost_q <= trial_cost_i;
    if (upd_go) snap_q <= state_nxt;
    if (out_adv && snap_vld_q) begin
      out_q      <= snap_q;
      out_done_q <= done_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign gain_p_o      = $signed(out_q.gain[0]);
  assign gain_i_o      = $signed(out_q.gain[1]);
  assign gain_d_o      = $signed(out_q.gain[2]);
  assign step_p_o      = out_q.step[0];
  assign step_i_o      = out_q.step[1];
  assign step_d_o      = out_q.step[2];
  assign tuned_index_o = out_q.idx;
  assign trial_phase_o = cdgt_pkg::phase_code(out_q.phase);
  assign best_cost_o   = out_q.best;
  assign done_res_o    = out_done_q;

endmodule

// ----- rtl/cdgt_update.sv -----
// ----------------------------------------------------------------------------
// Gain tuner update
// One twiddle step: judge a trial cost and compute the next tuner state.
// ----------------------------------------------------------------------------
module cdgt_update (
  input  cdgt_pkg::tune_state_t cur_i,
  input  logic [31:0]           cost_i,
  output cdgt_pkg::tune_state_t nxt_o
);

  typedef enum logic [1:0] {
    MV_NONE  = 2'd0,
    MV_UP    = 2'd1,
    MV_DOWN2 = 2'd2
  } move_e;

  logic        better;
  logic        finished;
  logic        scale_en;
  logic [16:0] scale_k;
  move_e       mv;
  logic [1:0]  idx_next;
  logic [31:0] step_sel;
  logic [31:0] step_scaled;

  assign better   = cost_i < cur_i.best;
  assign idx_next = (cur_i.idx == cdgt_pkg::IDX_LAST) ? cdgt_pkg::IDX_FIRST
                                                      : cur_i.idx + 2'd1;

  always_comb begin
    unique case (cur_i.idx)
      2'd1:    step_sel = cur_i.step[1];
      2'd2:    step_sel = cur_i.step[2];
      default: step_sel = cur_i.step[0];
    endcase
  end

  // Single shared scaler for the tuned step.
  assign step_scaled = cdgt_pkg::scale_step(step_sel, scale_k);

  always_comb begin
    logic signed [34:0] g_ext;
    logic signed [34:0] s_ext;
    nxt_o    = cur_i;
    finished = 1'b0;
    scale_en = 1'b0;
    scale_k  = cdgt_pkg::K_SHRINK;
    mv       = MV_NONE;

    unique case (cur_i.phase)
      cdgt_pkg::PH_FIRST: begin
        nxt_o.best  = cost_i;
        mv          = MV_UP;
        nxt_o.phase = cdgt_pkg::PH_POS;
      end
      cdgt_pkg::PH_POS: begin
        if (better) begin
          nxt_o.best = cost_i;
          scale_en   = 1'b1;
          scale_k    = cdgt_pkg::K_WIDEN_POS;
          finished   = 1'b1;
        end else begin
          mv          = MV_DOWN2;
          nxt_o.phase = cdgt_pkg::PH_NEG;
        end
      end
      cdgt_pkg::PH_NEG: begin
        finished = 1'b1;
        scale_en = 1'b1;
        if (better) begin
          nxt_o.best = cost_i;
          scale_k    = cdgt_pkg::K_WIDEN_NEG;
        end else begin
          mv      = MV_UP;
          scale_k = cdgt_pkg::K_SHRINK;
        end
      end
      default: ;
    endcase

    if (finished) begin
      nxt_o.idx   = idx_next;
      nxt_o.phase = cdgt_pkg::PH_POS;
    end

    // Lanes: the tuned gain moves by its own step, the next gain steps up on rotation.
    for (int k = 0; k < cdgt_pkg::NumGains; k++) begin
      g_ext = $signed({{3{cur_i.gain[k][31]}}, cur_i.gain[k]});
      s_ext = $signed({3'b000, cur_i.step[k]});
      if (cur_i.idx == 2'(k) && mv == MV_UP) begin
        nxt_o.gain[k] = cdgt_pkg::sat_gain(g_ext + s_ext);
      end else if (cur_i.idx == 2'(k) && mv == MV_DOWN2) begin
        nxt_o.gain[k] = cdgt_pkg::sat_gain(g_ext - (s_ext <<< 1));
      end else if (finished && idx_next == 2'(k)) begin
        nxt_o.gain[k] = cdgt_pkg::sat_gain(g_ext + s_ext);
      end
      if (cur_i.idx == 2'(k) && scale_en) begin
        nxt_o.step[k] = step_scaled;
      end
    end
  end

endmodule

// ----- rtl/cdgt_checker.sv -----
// ----------------------------------------------------------------------------
// Gain tuner checker
// Port-level assertions on the tuner results, bound to the top level.
// ----------------------------------------------------------------------------
`include "coordinate_descent_gain_tuner_macros.svh"

module cdgt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  tuned_index_o,
  input logic [1:0]  trial_phase_o,
  input logic [31:0] best_cost_o,
  input logic        done_res_o
);

  logic        index_bad;
  logic        phase_side;
  logic        cost_low;
  logic        out_wait;
  logic [33:0] shown;

  assign index_bad  = tuned_index_o > cdgt_pkg::IDX_LAST;
  assign phase_side = (trial_phase_o == cdgt_pkg::PHASE_CODE_POS) ||
                      (trial_phase_o == cdgt_pkg::PHASE_CODE_NEG);
  assign cost_low   = best_cost_o < cdgt_pkg::COST_ONE;
  assign out_wait   = out_valid_o && out_stall_i;
  assign shown      = {best_cost_o, tuned_index_o};

  // The tuned gain index only ever rotates over the three gains.
  `CDGT_ASSERT_NEVER(a_index_range, out_valid_o && index_bad, "tuned index out of range")

  // After any cost the tuner sits on the positive or the negative side.
  `CDGT_ASSERT(a_phase_after_item, out_valid_o |-> phase_side, "result phase not a side trial")

  // Done needs a best cost below 1.0.
  `CDGT_ASSERT(a_done_cost, (out_valid_o && done_res_o) |-> cost_low, "done with high best cost")

  // A stalled result stays valid and holds its best cost and tuned index.
  `CDGT_ASSERT(a_out_hold, out_wait |=> (out_valid_o && $stable(shown)), "stalled result changed")

endmodule

bind coordinate_descent_gain_tuner cdgt_checker u_cdgt_checker (.*);
